[design/lru_pr_pkg.sv]
// Shared constants for the LRU page replacement block.
package lru_pr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int CFG_W   = 5;
  localparam int CNT_W   = 5;
  localparam int FAULT_W = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [ADDR_W-1:0] REG_FRAMES_ADDR = 3'd0;
  localparam logic [CFG_W-1:0]  FRAMES_RESET    = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX      = '1;

endpackage

[design/lru_pr_cell.sv]
// One entry of the recency chain: compare against the reference, take the neighbour's page.
module lru_pr_cell #(
  parameter int PAGE_BITS = 16,
  parameter int OCC_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [PAGE_BITS-1:0] page,
  input  logic [OCC_W-1:0]     occ,
  input  logic [PAGE_BITS-1:0] prev_entry,
  input  logic                 found_in,
  output logic [PAGE_BITS-1:0] entry,
  output logic                 found_out
);

  logic valid;
  logic match;

  assign valid     = OCC_W'(IDX) < occ;
  assign match     = valid && (entry == page);
  assign found_out = found_in | match;

  // shift one place down unless the page sits above this cell
  always_ff @(posedge clk) begin
    if (en && !found_in) begin
      entry <= prev_entry;
    end
  end

endmodule

[design/lru_page_replacement.sv]
// Top level of the LRU page replacement block: command port, cell chain, counters, APB register.
//
// Usage:
//   Present page_number and last_reference with start high; the reference is taken
//   at the rising edge where start is high and busy is low.
//   busy is high for one cycle while the cell chain searches and reorders.
//   The result (was_hit, fault_total, resident_count, trace_done) is shown for exactly
//   one cycle with done high, the cycle after busy; the receiver cannot stall it.
//   Acceptance sets busy, and done and the result are registered from busy.
//   No reference is taken while busy is high; start may be held high, and a new
//   reference is taken in the same cycle its predecessor's result is shown.
//   busy covers the single pass through the chain: every cell compares its
//   entry and the found flag ripples down the row, then all cells shift together.
//   frames_in_use lives at APB byte address 0; writes take effect at once and drop
//   the least recently used pages beyond the new limit. Write it only while idle.
//   Reset (rst, synchronous) empties the table, clears the fault count and sets
//   frames_in_use to 16.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lru_pr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [PAGE_BITS-1:0]            page_number,
  input  logic                            last_reference,
  output logic                            done,
  output logic                            was_hit,
  output logic [lru_pr_pkg::FAULT_W-1:0]  fault_total,
  output logic [lru_pr_pkg::CNT_W-1:0]    resident_count,
  output logic                            trace_done,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lru_pr_pkg::ADDR_W-1:0]   paddr,
  input  logic [lru_pr_pkg::DATA_W-1:0]   pwdata,
  output logic [lru_pr_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);

  import lru_pr_pkg::*;

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);

  logic [PAGE_BITS-1:0] req_page;
  logic                 req_done;
  logic [CFG_W-1:0]     frames_in_use;
  logic [OCC_W-1:0]     occupancy;
  logic [OCC_W-1:0]     occupancy_next;
  logic [FAULT_W-1:0]   fault_counter;
  logic [FAULT_W-1:0]   fault_counter_next;
  logic [OCC_W-1:0]     lim;
  logic [OCC_W-1:0]     cfg_lim;
  logic                 accept;
  logic                 cfg_write;
  logic                 hit;

  logic [PAGE_BITS-1:0] entry [MAX_FRAMES];
  logic [PAGE_BITS-1:0] prev  [MAX_FRAMES];
  logic                 found [MAX_FRAMES+1];

  function automatic logic [OCC_W-1:0] clamp_lim(input logic [CFG_W-1:0] f);
    logic [OCC_W-1:0] r;
    if (f == '0) begin
      r = OCC_W'(1);
    end else if (32'(f) > MAX_FRAMES) begin
      r = OCC_W'(MAX_FRAMES);
    end else begin
      r = OCC_W'(f);
    end
    return r;
  endfunction

  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_FRAMES_ADDR);
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_FRAMES_ADDR) ? DATA_W'(frames_in_use) : '0;
  assign lim       = clamp_lim(frames_in_use);
  assign cfg_lim   = clamp_lim(pwdata[CFG_W-1:0]);

  assign found[0] = 1'b0;
  assign hit      = found[MAX_FRAMES];

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = req_page;
    end else begin : g_body
      assign prev[i] = entry[i-1];
    end

    lru_pr_cell #(
      .PAGE_BITS(PAGE_BITS),
      .OCC_W    (OCC_W),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .en        (busy),
      .page      (req_page),
      .occ       (occupancy),
      .prev_entry(prev[i]),
      .found_in  (found[i]),
      .entry     (entry[i]),
      .found_out (found[i+1])
    );
  end

  always_comb begin
    occupancy_next     = occupancy;
    fault_counter_next = fault_counter;
    if (!hit) begin
      occupancy_next = (occupancy >= lim) ? lim : occupancy + OCC_W'(1);
      if (fault_counter != FAULT_MAX) begin
        fault_counter_next = fault_counter + FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page <= page_number;
      req_done <= last_reference;
    end
    if (busy) begin
      was_hit        <= hit;
      fault_total    <= fault_counter_next;
      resident_count <= CNT_W'(occupancy_next);
      trace_done     <= req_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      done          <= 1'b0;
      occupancy     <= '0;
      fault_counter <= '0;
      frames_in_use <= FRAMES_RESET;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        occupancy     <= occupancy_next;
        fault_counter <= fault_counter_next;
      end else if (cfg_write) begin
        frames_in_use <= pwdata[CFG_W-1:0];
        if (occupancy > cfg_lim) begin
          occupancy <= cfg_lim;
        end
      end
    end
  end

endmodule

[design/lru_pr_checker.sv]
// Port-level checks of the command handshake and result timing, bound to the top level.
module lru_pr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done set after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("busy not followed by a single result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without start");

endmodule

bind lru_page_replacement lru_pr_checker u_lru_pr_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);
